// ----- src/variable_partition_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Variable partition allocator assertion macros
// Shared concurrent assertion helpers clocked on i_clk, gated by reset.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define VPA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vpa: same-cycle check failed");

// Next-cycle implication.
`define VPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vpa: next-cycle check failed");

`endif

// ----- src/vpa_pkg.sv -----
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared constants, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package vpa_pkg;

    localparam int LEN_BITS  = 16;
    localparam int DATA_BITS = 16;

    localparam logic [15:0] RESET_MEM_SIZE = 16'd1024;
    localparam logic [15:0] RESET_MIN_FRAG = 16'd10;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd4;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;

    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] CFG_POLICY   = 2'd0;
    localparam logic [1:0] CFG_MEM_SIZE = 2'd1;
    localparam logic [1:0] CFG_MIN_FRAG = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       pick;
        logic       cinit;
        logic       cstep;
        logic       slot;
        logic       grant;
        logic       find;
        logic       coal;
        logic       rel;
        logic       adv;
        logic       fin;
        logic [2:0] code;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_alloc;
        logic is_release;
        logic size_zero;
        logic table_full;
        logic count_zero;
        logic free_last;
        logic found;
        logic total_ok;
        logic cmp_last;
        logic slot_done;
        logic pid_hit;
        logic find_last;
        logic rel_full;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- src/vpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer that steps the datapath through the scans of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module vpa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire vpa_pkg::t_dp_sts i_sts,
    output vpa_pkg::t_dp_ctl      o_ctl
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_CHECK   = 10'b00_0000_0010,
        S_PICK    = 10'b00_0000_0100,
        S_PICKEND = 10'b00_0000_1000,
        S_CMPT    = 10'b00_0001_0000,
        S_SLOT    = 10'b00_0010_0000,
        S_GRANT   = 10'b00_0100_0000,
        S_FIND    = 10'b00_1000_0000,
        S_COAL    = 10'b01_0000_0000,
        S_REL     = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.is_alloc) begin
                    if (i_sts.size_zero) begin
                        o_ctl.fin  = 1'b1;
                        o_ctl.code = vpa_pkg::ST_BAD_SIZE;
                        n_state    = S_IDLE;
                    end else if (i_sts.table_full) begin
                        o_ctl.fin  = 1'b1;
                        o_ctl.code = vpa_pkg::ST_TABLE_FULL;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_PICK;
                    end
                end else if (i_sts.count_zero) begin
                    o_ctl.fin  = 1'b1;
                    o_ctl.code = vpa_pkg::ST_NOT_FOUND;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_FIND;
                end
            end
            S_PICK: begin
                o_ctl.pick = 1'b1;
                if (i_sts.free_last) begin
                    n_state = S_PICKEND;
                end else begin
                    o_ctl.adv = 1'b1;
                end
            end
            S_PICKEND: begin
                if (i_sts.found) begin
                    n_state = S_SLOT;
                end else if (i_sts.total_ok) begin
                    o_ctl.cinit = 1'b1;
                    n_state     = i_sts.count_zero ? S_SLOT : S_CMPT;
                end else begin
                    o_ctl.fin  = 1'b1;
                    o_ctl.code = vpa_pkg::ST_NO_SPACE;
                    n_state    = S_IDLE;
                end
            end
            S_CMPT: begin
                o_ctl.cstep = 1'b1;
                if (i_sts.cmp_last) begin
                    n_state = S_SLOT;
                end else begin
                    o_ctl.adv = 1'b1;
                end
            end
            S_SLOT: begin
                o_ctl.slot = 1'b1;
                if (i_sts.slot_done) begin
                    n_state = S_GRANT;
                end else begin
                    o_ctl.adv = 1'b1;
                end
            end
            S_GRANT: begin
                o_ctl.grant = 1'b1;
                o_ctl.fin   = 1'b1;
                o_ctl.code  = vpa_pkg::ST_OK;
                n_state     = S_IDLE;
            end
            S_FIND: begin
                o_ctl.find = 1'b1;
                if (i_sts.pid_hit) begin
                    if (i_sts.is_release) begin
                        n_state = S_COAL;
                    end else begin
                        o_ctl.fin  = 1'b1;
                        o_ctl.code = vpa_pkg::ST_OK;
                        n_state    = S_IDLE;
                    end
                end else if (i_sts.find_last) begin
                    o_ctl.fin  = 1'b1;
                    o_ctl.code = vpa_pkg::ST_NOT_FOUND;
                    n_state    = S_IDLE;
                end else begin
                    o_ctl.adv = 1'b1;
                end
            end
            S_COAL: begin
                o_ctl.coal = 1'b1;
                if (i_sts.free_last) begin
                    n_state = S_REL;
                end else begin
                    o_ctl.adv = 1'b1;
                end
            end
            S_REL: begin
                o_ctl.rel  = 1'b1;
                o_ctl.fin  = 1'b1;
                o_ctl.code = i_sts.rel_full ? vpa_pkg::ST_NO_SPACE : vpa_pkg::ST_OK;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/vpa_dp.sv -----
// ----------------------------------------------------------------------------
// vpa_dp
// Free and used tables, scan counter, selection and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module vpa_dp #(
    parameter int FREE_ENTRIES = 16,
    parameter int USED_ENTRIES = 16,
    parameter int ADDR_BITS    = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [15:0]      i_cfg_wdata,
    input  wire logic [1:0]       i_command,
    input  wire logic [15:0]      i_request_size,
    input  wire logic [15:0]      i_target_pid,
    input  wire vpa_pkg::t_dp_ctl i_ctl,
    output vpa_pkg::t_dp_sts      o_sts,
    output logic                  o_done,
    output logic [2:0]            o_status,
    output logic [15:0]           o_process_id,
    output logic [15:0]           o_start_address,
    output logic [15:0]           o_granted_size,
    output logic                  o_compacted
);

    localparam int FW   = $clog2(FREE_ENTRIES);
    localparam int UW   = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
    localparam int CW   = $clog2(USED_ENTRIES + 1);
    localparam int MAXE = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
    localparam int IW   = $clog2(MAXE);
    localparam int KW   = (IW > CW) ? IW : CW;
    localparam int LW   = vpa_pkg::LEN_BITS;
    localparam int AW   = ADDR_BITS;
    localparam int SW   = ((AW > LW) ? AW : LW) + 1;
    localparam int TW   = LW + FW;

    // Tables.
    logic [AW-1:0]           r_fstart [FREE_ENTRIES];
    logic [LW-1:0]           r_flen   [FREE_ENTRIES];
    logic [FREE_ENTRIES-1:0] r_fvalid;
    logic [15:0]             r_upid   [USED_ENTRIES];
    logic [AW-1:0]           r_ustart [USED_ENTRIES];
    logic [LW-1:0]           r_ulen   [USED_ENTRIES];
    logic [USED_ENTRIES-1:0] r_ulive;
    logic [UW-1:0]           r_age    [USED_ENTRIES];
    logic [CW-1:0]           r_count;

    // Configuration and request.
    logic [1:0]    r_policy;
    logic [LW-1:0] r_min_frag;
    logic [1:0]    r_cmd;
    logic [15:0]   r_size;
    logic [15:0]   r_target;
    logic [15:0]   r_next_pid;

    // Scan state.
    logic [IW-1:0] r_idx;
    logic          r_found;
    logic [FW-1:0] r_best_idx;
    logic [LW-1:0] r_best_len;
    logic [AW-1:0] r_best_start;
    logic [TW-1:0] r_total;
    logic [TW-1:0] r_caddr;
    logic [UW-1:0] r_slot;
    logic          r_comp;
    logic [UW-1:0] r_hit_k;
    logic [UW-1:0] r_hit_slot;
    logic [AW-1:0] r_rstart;
    logic [LW-1:0] r_rlen;
    logic          r_prev_ok;
    logic [FW-1:0] r_prev;
    logic [LW-1:0] r_prev_len;
    logic          r_next_ok;
    logic [FW-1:0] r_next;
    logic [LW-1:0] r_next_len;
    logic          r_empty_ok;
    logic [FW-1:0] r_empty;

    // Result registers.
    logic          r_done;
    logic [2:0]    r_o_status;
    logic [15:0]   r_o_pid;
    logic [15:0]   r_o_start;
    logic [15:0]   r_o_len;
    logic          r_o_comp;

    logic [FW-1:0] fi;
    logic [UW-1:0] ui;
    logic [UW-1:0] age_slot;
    logic [LW-1:0] e_len;
    logic [AW-1:0] e_st;
    logic          e_val;
    logic          fits;
    logic          better;
    logic          take;
    logic [LW-1:0] rem;
    logic          split;
    logic [LW-1:0] granted;
    logic [SW-1:0] e_end;
    logic [SW-1:0] rel_end;
    logic          prev_hit;
    logic          next_hit;
    logic          rel_full;
    logic          memsize_we;
    logic          look_hit;

    assign fi       = r_idx[FW-1:0];
    assign ui       = r_idx[UW-1:0];
    assign age_slot = r_age[ui];
    assign e_len    = r_flen[fi];
    assign e_st     = r_fstart[fi];
    assign e_val    = r_fvalid[fi];
    assign fits     = e_val && (e_len >= r_size);

    // Policy compare against the current best; ties keep the lower address.
    always_comb begin
        if (r_policy == vpa_pkg::POL_BEST) begin
            better = (e_len < r_best_len) || ((e_len == r_best_len) && (e_st < r_best_start));
        end else if (r_policy == vpa_pkg::POL_WORST) begin
            better = (e_len > r_best_len) || ((e_len == r_best_len) && (e_st < r_best_start));
        end else begin
            better = (e_st < r_best_start);
        end
    end

    assign take    = fits && (!r_found || better);
    assign rem     = r_best_len - r_size;
    assign split   = (rem != '0) && (rem >= r_min_frag);
    assign granted = split ? r_size : r_best_len;

    assign e_end    = SW'(e_st) + SW'(e_len);
    assign rel_end  = SW'(r_rstart) + SW'(r_rlen);
    assign prev_hit = e_val && (e_end == SW'(r_rstart));
    assign next_hit = e_val && !prev_hit && (SW'(e_st) == rel_end);
    assign rel_full = !r_prev_ok && !r_next_ok && !r_empty_ok;

    assign memsize_we = i_cfg_we && (i_cfg_idx == vpa_pkg::CFG_MEM_SIZE);

    // A lookup finishes in the cycle of its match, so its block is taken
    // straight from the used table.
    assign look_hit = i_ctl.find && o_sts.pid_hit;

    always_comb begin
        o_sts.is_alloc   = (r_cmd == vpa_pkg::CMD_ALLOC);
        o_sts.is_release = (r_cmd == vpa_pkg::CMD_RELEASE);
        o_sts.size_zero  = (r_size == '0);
        o_sts.table_full = (r_count == CW'(USED_ENTRIES));
        o_sts.count_zero = (r_count == '0);
        o_sts.free_last  = (r_idx == IW'(FREE_ENTRIES - 1));
        o_sts.found      = r_found;
        o_sts.total_ok   = (r_total >= TW'(r_size));
        o_sts.cmp_last   = ((KW'(r_idx) + KW'(1)) == KW'(r_count));
        o_sts.slot_done  = !r_ulive[ui] || (KW'(r_idx) == KW'(USED_ENTRIES - 1));
        o_sts.pid_hit    = (r_upid[age_slot] == r_target);
        o_sts.find_last  = ((KW'(r_idx) + KW'(1)) == KW'(r_count));
        o_sts.rel_full   = rel_full;
    end

    // Free table: entry 0 holds the whole space after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid    <= FREE_ENTRIES'(1);
            r_fstart[0] <= '0;
            r_flen[0]   <= LW'(vpa_pkg::RESET_MEM_SIZE);
        end else if (memsize_we) begin
            r_fvalid    <= (i_cfg_wdata != '0) ? FREE_ENTRIES'(1) : '0;
            r_fstart[0] <= '0;
            r_flen[0]   <= LW'(i_cfg_wdata);
        end else if (i_ctl.cinit) begin
            r_fvalid    <= FREE_ENTRIES'(1);
            r_fstart[0] <= '0;
            r_flen[0]   <= r_total[LW-1:0];
        end else if (i_ctl.grant) begin
            if (split) begin
                r_fstart[r_best_idx] <= r_best_start + AW'(r_size);
                r_flen[r_best_idx]   <= rem;
            end else begin
                r_fvalid[r_best_idx] <= 1'b0;
            end
        end else if (i_ctl.rel) begin
            if (r_prev_ok && r_next_ok) begin
                r_flen[r_prev]   <= r_prev_len + r_rlen + r_next_len;
                r_fvalid[r_next] <= 1'b0;
            end else if (r_prev_ok) begin
                r_flen[r_prev] <= r_prev_len + r_rlen;
            end else if (r_next_ok) begin
                r_fstart[r_next] <= r_rstart;
                r_flen[r_next]   <= r_next_len + r_rlen;
            end else if (r_empty_ok) begin
                r_fvalid[r_empty] <= 1'b1;
                r_fstart[r_empty] <= r_rstart;
                r_flen[r_empty]   <= r_rlen;
            end
        end
    end

    // Used table payload.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cstep) begin
            r_ustart[age_slot] <= AW'(r_caddr);
        end
        if (i_ctl.grant) begin
            r_upid[r_slot]   <= r_next_pid;
            r_ustart[r_slot] <= r_best_start;
            r_ulen[r_slot]   <= granted;
        end
    end

    // Live slots and the newest-first age list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ulive <= '0;
            r_count <= '0;
        end else if (memsize_we) begin
            r_ulive <= '0;
            r_count <= '0;
        end else if (i_ctl.grant) begin
            r_ulive[r_slot] <= 1'b1;
            r_count         <= r_count + CW'(1);
            r_age[0]        <= r_slot;
            for (int k = 1; k < USED_ENTRIES; k++) begin
                r_age[k] <= r_age[k-1];
            end
        end else if (i_ctl.rel && !rel_full) begin
            r_ulive[r_hit_slot] <= 1'b0;
            r_count             <= r_count - CW'(1);
            for (int j = 0; j < USED_ENTRIES - 1; j++) begin
                if (UW'(j) >= r_hit_k) begin
                    r_age[j] <= r_age[j+1];
                end
            end
        end
    end

    // Request, scan and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= '0;
            r_min_frag <= LW'(vpa_pkg::RESET_MIN_FRAG);
            r_next_pid <= '0;
            r_idx      <= '0;
            r_done     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vpa_pkg::CFG_POLICY:   r_policy   <= i_cfg_wdata[1:0];
                    vpa_pkg::CFG_MIN_FRAG: r_min_frag <= LW'(i_cfg_wdata);
                    default: ;
                endcase
            end

            r_done <= i_ctl.fin;
            r_idx  <= i_ctl.adv ? (r_idx + IW'(1)) : '0;

            if (i_ctl.load) begin
                r_cmd      <= i_command;
                r_size     <= i_request_size;
                r_target   <= i_target_pid;
                r_found    <= 1'b0;
                r_total    <= '0;
                r_comp     <= 1'b0;
                r_rstart   <= '0;
                r_rlen     <= '0;
                r_prev_ok  <= 1'b0;
                r_next_ok  <= 1'b0;
                r_empty_ok <= 1'b0;
                if (i_command == vpa_pkg::CMD_ALLOC) begin
                    r_next_pid <= r_next_pid + 16'd1;
                end
            end

            if (i_ctl.pick) begin
                if (take) begin
                    r_found      <= 1'b1;
                    r_best_idx   <= fi;
                    r_best_len   <= e_len;
                    r_best_start <= e_st;
                end
                if (e_val) begin
                    r_total <= r_total + TW'(e_len);
                end
            end

            if (i_ctl.cinit) begin
                r_best_idx   <= '0;
                r_best_len   <= r_total[LW-1:0];
                r_best_start <= '0;
                r_comp       <= 1'b1;
                r_caddr      <= r_total;
            end

            if (i_ctl.cstep) begin
                r_caddr <= r_caddr + TW'(r_ulen[age_slot]);
            end

            if (i_ctl.slot) begin
                r_slot <= ui;
            end

            if (look_hit) begin
                r_hit_k    <= ui;
                r_hit_slot <= age_slot;
                r_rstart   <= r_ustart[age_slot];
                r_rlen     <= r_ulen[age_slot];
            end

            if (i_ctl.coal) begin
                if (prev_hit) begin
                    r_prev_ok  <= 1'b1;
                    r_prev     <= fi;
                    r_prev_len <= e_len;
                end
                if (next_hit) begin
                    r_next_ok  <= 1'b1;
                    r_next     <= fi;
                    r_next_len <= e_len;
                end
                if (!e_val && !r_empty_ok) begin
                    r_empty_ok <= 1'b1;
                    r_empty    <= fi;
                end
            end

            if (i_ctl.fin) begin
                r_o_status <= i_ctl.code;
                r_o_pid    <= o_sts.is_alloc ? r_next_pid : r_target;
                if (i_ctl.grant) begin
                    r_o_start <= 16'(r_best_start);
                    r_o_len   <= 16'(granted);
                end else if (look_hit) begin
                    r_o_start <= 16'(r_ustart[age_slot]);
                    r_o_len   <= 16'(r_ulen[age_slot]);
                end else begin
                    r_o_start <= 16'(r_rstart);
                    r_o_len   <= 16'(r_rlen);
                end
                r_o_comp   <= r_comp;
            end
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_o_status;
    assign o_process_id    = r_o_pid;
    assign o_start_address = r_o_start;
    assign o_granted_size  = r_o_len;
    assign o_compacted     = r_o_comp;

endmodule

`default_nettype wire

// ----- src/variable_partition_allocator.sv -----
// ----------------------------------------------------------------------------
// variable_partition_allocator
// First, best or worst fit allocator with release coalescing and compaction.
// ----------------------------------------------------------------------------
// A lookup scans the age list, newest first, until it matches; a release
// adds a scan of the free table for neighbors; an allocate scans the free
// table, then the used table for a free slot, plus a compaction pass over the
// live blocks when it compacts. One request at a time: o_busy is high until the
// result beat, which is shown for one cycle and cannot be stalled. Sync reset
// leaves one free block [0, 1024), no live blocks, policy first fit.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_partition_allocator #(
    parameter int FREE_ENTRIES = 16,
    parameter int USED_ENTRIES = 16,
    parameter int ADDR_BITS    = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port: 0 policy, 1 memory size, 2 minimum fragment.
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata,
    // Request beat, taken when i_start is high and o_busy is low.
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_request_size,
    input  wire logic [15:0] i_target_pid,
    // Result beat, valid for the single cycle o_done is high.
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [15:0]      o_process_id,
    output logic [15:0]      o_start_address,
    output logic [15:0]      o_granted_size,
    output logic             o_compacted
);

    // The controller walks each request through its scans; the datapath owns
    // the tables and does one table entry of work per cycle.
    vpa_pkg::t_dp_ctl ctl;
    vpa_pkg::t_dp_sts sts;

    vpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    vpa_dp #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .USED_ENTRIES (USED_ENTRIES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_command       (i_command),
        .i_request_size  (i_request_size),
        .i_target_pid    (i_target_pid),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_process_id    (o_process_id),
        .o_start_address (o_start_address),
        .o_granted_size  (o_granted_size),
        .o_compacted     (o_compacted)
    );

endmodule

`default_nettype wire

// ----- src/vpa_checker.sv -----
// ----------------------------------------------------------------------------
// vpa_checker
// Port-level checks on the request and result beats of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "variable_partition_allocator_defines.svh"

module vpa_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic       o_busy,
    input wire logic       o_done,
    input wire logic [2:0] o_status,
    input wire logic       o_compacted
);

    // An accepted request makes the block busy in the next cycle.
    `VPA_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy)
    // The result beat comes as the block goes idle.
    `VPA_ASSERT_NOW(a_done_idle, o_done, !o_busy)
    // Result beats are never back to back.
    `VPA_ASSERT_NEXT(a_done_single, o_done, !o_done)
    // Compaction is only reported on a successful grant.
    `VPA_ASSERT_NOW(a_comp_ok, o_done && o_compacted, o_status == vpa_pkg::ST_OK)

endmodule

bind variable_partition_allocator vpa_checker u_vpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_done      (o_done),
    .o_status    (o_status),
    .o_compacted (o_compacted)
);

`default_nettype wire
